// ===== design/png_scanline_unfilter_assert.svh =====
// assertion macros shared by the checker
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("png_scanline_unfilter assertion failed");

// antecedent implies consequent in the next cycle
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("png_scanline_unfilter assertion failed");

`endif

// ===== design/png_unf_pkg.sv =====
package png_unf_pkg;

    localparam int COL_W    = 15;
    localparam int ROW_W    = 16;
    localparam int BPP_W    = 4;
    localparam int SEL_W    = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] REG_BPP       = 2'd0;
    localparam logic [1:0] REG_ROW_BYTES = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT = 2'd2;

    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;

    typedef struct packed {
        logic [BPP_W-1:0] bpp;
        logic [COL_W-1:0] row_bytes;
        logic [ROW_W-1:0] row_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       data;
        logic [2:0]       kind;
        logic             invalid;
        logic             first_row;
        logic             left_ok;
        logic [SEL_W-1:0] sel;
        logic             eor;
        logic             eoi;
        logic [COL_W-1:0] col;
    } t_item;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] sa;
        logic signed [9:0] sb;
        logic signed [9:0] sc;
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [7:0]        res;
        sa = $signed({2'b00, a});
        sb = $signed({2'b00, b});
        sc = $signed({2'b00, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) begin
            res = a;
        end else if (db <= dc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

// ===== design/png_unf_cfg.sv =====
module png_unf_cfg
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [BPP_W-1:0] r_bpp;
    logic [COL_W-1:0] r_row_bytes;
    logic [ROW_W-1:0] r_row_count;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_W'(4);
            r_row_bytes <= COL_W'(4096);
            r_row_count <= ROW_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_BPP:       r_bpp       <= pwdata[BPP_W-1:0];
                REG_ROW_BYTES: r_row_bytes <= pwdata[COL_W-1:0];
                REG_ROW_COUNT: r_row_count <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BPP:       prdata = PDATA_W'(r_bpp);
            REG_ROW_BYTES: prdata = PDATA_W'(r_row_bytes);
            REG_ROW_COUNT: prdata = PDATA_W'(r_row_count);
            default:       prdata = '0;
        endcase
    end

    // effective values with out-of-range settings clamped
    always_comb begin
        if (r_bpp == '0) begin
            o_cfg.bpp = BPP_W'(1);
        end else if (r_bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
            o_cfg.bpp = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            o_cfg.bpp = r_bpp;
        end

        if (r_row_bytes == '0) begin
            o_cfg.row_bytes = COL_W'(1);
        end else if (17'(r_row_bytes) > 17'(MAX_ROW_BYTES)) begin
            o_cfg.row_bytes = COL_W'(MAX_ROW_BYTES);
        end else begin
            o_cfg.row_bytes = r_row_bytes;
        end

        o_cfg.row_count = (r_row_count == '0) ? ROW_W'(1) : r_row_count;
    end

endmodule

// ===== design/png_unf_ctrl.sv =====
module png_unf_ctrl
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 16384
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_item      o_item
);

    localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int CW  = (AW < COL_W) ? AW : COL_W;

    logic          r_awaiting;
    logic [CW-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [2:0]    r_kind;
    logic          r_invalid;

    logic          eor;
    logic          eoi;

    assign eor = (17'(r_col) + 17'd1) >= 17'(i_cfg.row_bytes);
    assign eoi = eor && ((17'(r_row) + 17'd1) >= 17'(i_cfg.row_count));

    assign o_push          = i_accept && !r_awaiting;
    assign o_item.data      = i_byte;
    assign o_item.kind      = r_kind;
    assign o_item.invalid   = r_invalid;
    assign o_item.first_row = (r_row == '0);
    assign o_item.left_ok   = 16'(r_col) >= 16'(i_cfg.bpp);
    assign o_item.sel       = SEL_W'(i_cfg.bpp - BPP_W'(1));
    assign o_item.eor       = eor;
    assign o_item.eoi       = eoi;
    assign o_item.col       = COL_W'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
            r_kind     <= FLT_NONE;
            r_invalid  <= 1'b0;
        end else if (i_accept) begin
            if (r_awaiting) begin
                r_awaiting <= 1'b0;
                r_col      <= '0;
                if (i_byte <= 8'(FLT_PAETH)) begin
                    r_kind    <= i_byte[2:0];
                    r_invalid <= 1'b0;
                end else begin
                    r_kind    <= FLT_NONE;
                    r_invalid <= 1'b1;
                end
            end else if (eor) begin
                r_awaiting <= 1'b1;
                r_col      <= '0;
                r_row      <= eoi ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

endmodule

// ===== design/png_unf_recon.sv =====
module png_unf_recon
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_item      i_item,
    output logic       o_take,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_pixel_byte,
    output logic       o_end_of_row,
    output logic       o_end_of_image,
    output logic       o_bad_filter
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [7:0]  r_mem [MAX_ROW_BYTES];
    logic [7:0]  r_mem_q;
    t_item       r_s1;
    logic        r_s1_valid;
    logic [7:0]  r_left [MAX_PIXEL_BYTES];
    logic [7:0]  r_upleft [MAX_PIXEL_BYTES];
    logic        r_out_valid;
    logic [7:0]  r_pixel;
    logic        r_eor;
    logic        r_eoi;
    logic        r_bad;

    logic        adv;
    logic [7:0]  above;
    logic [7:0]  left;
    logic [7:0]  upleft;
    logic [8:0]  avg_sum;
    logic [7:0]  pred;
    logic [7:0]  n_value;
    logic [HW-1:0] hsel;

    assign adv    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_take = !r_s1_valid || adv;

    assign hsel    = HW'(r_s1.sel);
    assign above   = r_s1.first_row ? 8'd0 : r_mem_q;
    assign left    = r_s1.left_ok ? r_left[hsel] : 8'd0;
    assign upleft  = (r_s1.left_ok && !r_s1.first_row) ? r_upleft[hsel] : 8'd0;
    assign avg_sum = {1'b0, left} + {1'b0, above};

    always_comb begin
        if (r_s1.invalid) begin
            pred = 8'd0;
        end else begin
            case (r_s1.kind)
                FLT_SUB:   pred = left;
                FLT_UP:    pred = above;
                FLT_AVG:   pred = avg_sum[8:1];
                FLT_PAETH: pred = paeth(left, above, upleft);
                default:   pred = 8'd0;
            endcase
        end
    end

    assign n_value = r_s1.data + pred;

    // row store with one read and one write port: read on push, write back on advance
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem_q <= r_mem[AW'(i_item.col)];
        end
        if (adv) begin
            r_mem[AW'(r_s1.col)] <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1 <= i_item;
        end
        if (adv) begin
            r_pixel <= n_value;
            r_eor   <= r_s1.eor;
            r_eoi   <= r_s1.eoi;
            r_bad   <= r_s1.invalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= 8'd0;
                r_upleft[i] <= 8'd0;
            end
        end else begin
            if (i_push) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (adv) begin
                r_left[0]   <= n_value;
                r_upleft[0] <= above;
                for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                    r_left[i]   <= r_left[i-1];
                    r_upleft[i] <= r_upleft[i-1];
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_byte   = r_pixel;
    assign o_end_of_row   = r_eor;
    assign o_end_of_image = r_eoi;
    assign o_bad_filter   = r_bad;

endmodule

// ===== design/png_scanline_unfilter.sv =====
// PNG scanline unfilter for 8 and 16 bit samples: takes the inflated stream one byte per
// transaction and returns one reconstructed byte per sample byte, none for the filter type
// byte that opens each row. Filter bytes are taken like sample bytes. The accepting edge reads
// the previous-row store and registers the byte in the first stage; prediction, write-back
// into the same store and the output register load follow when that stage advances. The
// store has one read and one write port, so one byte per clock keeps flowing while the
// output is not blocked. o_in_ready drops only while a result waits at the output
// and the pipeline behind it is full. The row store holds no reset; rows longer than any row
// written before read undefined upper bytes. Registers (APB, byte address 4*i): pixel
// stride in bytes, row_bytes, row_count; write them only while the block is idle.
module png_scanline_unfilter
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_filtered_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_pixel_byte,
    output logic               o_end_of_row,
    output logic               o_end_of_image,
    output logic               o_bad_filter
);

    t_cfg  cfg;
    t_item item;
    logic  push;
    logic  take;
    logic  accept;

    assign o_in_ready = take;
    assign accept     = i_in_valid && take;

    png_unf_cfg #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    png_unf_ctrl #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_byte   (i_filtered_byte),
        .o_push   (push),
        .o_item   (item)
    );

    png_unf_recon #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_recon (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_item         (item),
        .o_take         (take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_byte   (o_pixel_byte),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_image (o_end_of_image),
        .o_bad_filter   (o_bad_filter)
    );

endmodule

// ===== design/png_unf_checker.sv =====
`include "png_scanline_unfilter_assert.svh"

module png_unf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pready,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [7:0]         o_pixel_byte,
    input logic               o_end_of_row,
    input logic               o_end_of_image,
    input logic               o_bad_filter
);

    logic [10:0] out_word;

    assign out_word = {o_pixel_byte, o_end_of_row, o_end_of_image, o_bad_filter};

    // a stalled result holds
    `PSU_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_word))

    // image end always closes a row
    `PSU_ASSERT_NOW(a_eoi_eor, o_out_valid && o_end_of_image, o_end_of_row)

    // input side stalls only behind a blocked result
    `PSU_ASSERT_NOW(a_ready_backpressure, !o_in_ready, o_out_valid && !i_out_ready)

    // register port never waits
    `PSU_ASSERT_NOW(a_pready, psel && penable, pready)

endmodule

bind png_scanline_unfilter png_unf_checker u_png_unf_checker (.*);
